// ===== hdl/bsc_pkg.sv =====
// -----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths, register indexes and small helpers.
// -----------------------------------------------------------------------------
package bsc_pkg;

	localparam int RawW   = 20;
	localparam int CoefW  = 48;
	localparam int IdxW   = 2;
	localparam int DivW   = 64;

	typedef enum logic [IdxW-1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} reg_idx_t;

	localparam logic [63:0] FineOffset = 64'd128000;
	localparam logic [63:0] FullScale  = 64'd1048576;
	localparam logic [63:0] Scale3125  = 64'd3125;

endpackage

// ===== hdl/bsc_stream_if.sv =====
// -----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload item.
// -----------------------------------------------------------------------------
interface bsc_stream_if #(parameter int W = 40);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/bsc_div.sv =====
// -----------------------------------------------------------------------------
// Pipelined divider
// Unsigned 64-bit restoring division, one quotient bit per stage.
// -----------------------------------------------------------------------------
module bsc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [bsc_pkg::DivW-1:0]  num,
	input  logic [bsc_pkg::DivW-1:0]  den,
	input  logic [95:0]               side_in,
	output logic                      out_valid,
	output logic [bsc_pkg::DivW-1:0]  quo,
	output logic [95:0]               side_out
);
	localparam int N = bsc_pkg::DivW;

	logic [N-1:0] rem_s1 [N+1];
	logic [N-1:0] num_s1 [N+1];
	logic [N-1:0] den_s1 [N+1];
	logic [95:0]  side_s1 [N+1];
	logic         vld_s1 [N+1];

	assign rem_s1[0]  = '0;
	assign num_s1[0]  = num;
	assign den_s1[0]  = den;
	assign side_s1[0] = side_in;
	assign vld_s1[0]  = in_valid;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N:0] trial;
		logic [N:0] shifted;
		logic [N-1:0] rem_q, num_q, den_q;
		logic [95:0] side_q;
		logic vld_q;
		// Shift the next numerator bit into the partial remainder and try a subtract.
		assign shifted = {rem_s1[k], num_s1[k][N-1]};
		assign trial   = shifted - {1'b0, den_s1[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (en) begin
				vld_q <= vld_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[N]) begin
					rem_q <= trial[N-1:0];
				end else begin
					rem_q <= shifted[N-1:0];
				end
				num_q  <= {num_s1[k][N-2:0], ~trial[N]};
				den_q  <= den_s1[k];
				side_q <= side_s1[k];
			end
		end
		assign rem_s1[k+1]  = rem_q;
		assign num_s1[k+1]  = num_q;
		assign den_s1[k+1]  = den_q;
		assign side_s1[k+1] = side_q;
		assign vld_s1[k+1]  = vld_q;
	end

	assign out_valid = vld_s1[N];
	assign quo       = num_s1[N];
	assign side_out  = side_s1[N];
endmodule

// ===== hdl/barometric_sensor_compensation.sv =====
// -----------------------------------------------------------------------------
// Barometric sensor compensation
// Integer calibration of raw temperature and pressure readings.
// -----------------------------------------------------------------------------
// The input channel carries raw_temp and raw_press; the output channel carries
// temp_centideg, press_q24_8 and div_zero, one result item per input item.
// Coefficients are written through cfg_we/cfg_idx/cfg_data while idle.
// The pipeline takes one item per cycle while the output is not stalled. It
// has 10 stages of temperature and pressure arithmetic, 64 stages of the
// bit-per-stage divider and 4 stages of post-division correction.
// The whole pipeline advances only while its last stage is empty or taken,
// so a stall on the output freezes every stage and nothing is lost; ready
// on the input follows that condition.
// Reset clears all valid bits and the coefficient registers to zero.
// A zero divisor gives a pressure of 0 with div_zero set.
module barometric_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bsc_pkg::IdxW-1:0]      cfg_idx,
	input  logic [bsc_pkg::CoefW-1:0]     cfg_data,
	bsc_stream_if.sink                    in_ch,
	bsc_stream_if.source                  out_ch
);
	logic [47:0] tc_q, pa_q, pb_q, pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bsc_pkg::REG_TEMP:    tc_q <= cfg_data;
				bsc_pkg::REG_PRESS_A: pa_q <= cfg_data;
				bsc_pkg::REG_PRESS_B: pb_q <= cfg_data;
				bsc_pkg::REG_PRESS_C: pc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [31:0] t1, t2, t3;
	logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, tc_q[15:0]};
	assign t2 = {{16{tc_q[31]}}, tc_q[31:16]};
	assign t3 = {{16{tc_q[47]}}, tc_q[47:32]};
	assign p1 = {48'd0, pa_q[15:0]};
	assign p2 = {{48{pa_q[31]}}, pa_q[31:16]};
	assign p3 = {{48{pa_q[47]}}, pa_q[47:32]};
	assign p4 = {{48{pb_q[15]}}, pb_q[15:0]};
	assign p5 = {{48{pb_q[31]}}, pb_q[31:16]};
	assign p6 = {{48{pb_q[47]}}, pb_q[47:32]};
	assign p7 = {{48{pc_q[15]}}, pc_q[15:0]};
	assign p8 = {{48{pc_q[31]}}, pc_q[31:16]};
	assign p9 = {{48{pc_q[47]}}, pc_q[47:32]};

	logic en;
	logic out_v;
	assign en = !out_v || out_ch.ready;
	assign in_ch.ready = en;

	logic [19:0] adt, adp;
	assign adt = in_ch.data[19:0];
	assign adp = in_ch.data[39:20];

	// Stage 1: temperature products.
	logic v_s1;
	logic signed [31:0] a_s1, dd_s1;
	logic [19:0] adp_s1;
	// Stage 2: a and b first step.
	logic v_s2;
	logic signed [31:0] a_s2, b_s2;
	logic [19:0] adp_s2;
	// Stage 3: fine temperature.
	logic v_s3;
	logic signed [31:0] fine_s3;
	logic [19:0] adp_s3;
	// Stage 4: temperature output and x.
	logic v_s4;
	logic signed [31:0] temp_s4;
	logic signed [63:0] x_s4;
	logic [19:0] adp_s4;
	// Stage 5: x squared and x products.
	logic v_s5;
	logic signed [63:0] xx_s5, xp5_s5, xp2_s5;
	logic signed [31:0] temp_s5;
	logic [19:0] adp_s5;
	// Stage 6: y and divisor terms.
	logic v_s6;
	logic signed [63:0] y_s6, d1_s6;
	logic signed [31:0] temp_s6;
	logic [19:0] adp_s6;
	// Stage 7: divisor product.
	logic v_s7;
	logic signed [63:0] y_s7, dv_s7;
	logic signed [31:0] temp_s7;
	logic [19:0] adp_s7;
	// Stage 8: divisor and numerator base.
	logic v_s8;
	logic signed [63:0] dv_s8, nb_s8;
	logic signed [31:0] temp_s8;
	// Stage 9: numerator times 3125.
	logic v_s9;
	logic signed [63:0] dv_s9, n_s9;
	logic signed [31:0] temp_s9;
	// Stage 10: magnitudes into the divider.
	logic v_s10;
	logic [63:0] mn_s10, md_s10;
	logic neg_s10, dz_s10;
	logic signed [31:0] temp_s10;

	logic signed [31:0] at_c, dt_c, dd_c;
	assign at_c = {15'd0, adt[19:3]} - (t1 <<< 1);
	assign dt_c = {16'd0, adt[19:4]} - t1;
	assign dd_c = dt_c * dt_c;

	// The fine temperature offset by 128000 always fits in 33 bits.
	logic signed [32:0] x33_c;
	assign x33_c = x_s4[32:0];

	logic signed [63:0] dv7_c;
	assign dv7_c = ((64'sd1 <<< 47) + dv_s7) * p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= (at_c * t2) >>> 11;
			dd_s1  <= dd_c >>> 12;
			adp_s1 <= adp;

			a_s2   <= a_s1;
			b_s2   <= (dd_s1 * t3) >>> 14;
			adp_s2 <= adp_s1;

			fine_s3 <= a_s2 + b_s2;
			adp_s3  <= adp_s2;

			temp_s4 <= (fine_s3 * 32'sd5 + 32'sd128) >>> 8;
			x_s4    <= {{32{fine_s3[31]}}, fine_s3} - $signed(bsc_pkg::FineOffset);
			adp_s4  <= adp_s3;

			xx_s5   <= x33_c * x33_c;
			xp5_s5  <= x33_c * p5;
			xp2_s5  <= x33_c * p2;
			temp_s5 <= temp_s4;
			adp_s5  <= adp_s4;

			y_s6    <= xx_s5 * p6 + (xp5_s5 <<< 17) + (p4 <<< 35);
			d1_s6   <= ((xx_s5 * p3) >>> 8) + (xp2_s5 <<< 12);
			temp_s6 <= temp_s5;
			adp_s6  <= adp_s5;

			y_s7    <= y_s6;
			dv_s7   <= d1_s6;
			temp_s7 <= temp_s6;
			adp_s7  <= adp_s6;

			dv_s8   <= dv7_c >>> 33;
			nb_s8   <= ((bsc_pkg::FullScale - {44'd0, adp_s7}) <<< 31) - y_s7;
			temp_s8 <= temp_s7;

			dv_s9   <= dv_s8;
			n_s9    <= nb_s8 * $signed(bsc_pkg::Scale3125);
			temp_s9 <= temp_s8;

			mn_s10   <= n_s9[63] ? -n_s9 : n_s9;
			md_s10   <= dv_s9[63] ? -dv_s9 : dv_s9;
			neg_s10  <= n_s9[63] ^ dv_s9[63];
			dz_s10   <= (dv_s9 == 64'sd0);
			temp_s10 <= temp_s9;
		end
	end

	logic        dv_v;
	logic [63:0] dq;
	logic [95:0] dside;
	bsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.num       (mn_s10),
		.den       (md_s10),
		.side_in   ({62'd0, neg_s10, dz_s10, temp_s10}),
		.out_valid (dv_v),
		.quo       (dq),
		.side_out  (dside)
	);

	// Post stage 1: sign of quotient and p>>>13.
	logic v_s11, dz_s11;
	logic signed [63:0] p_s11, ps_s11;
	logic signed [31:0] temp_s11;
	// Post stage 2: square of p>>>13 and product with p8.
	logic v_s12, dz_s12;
	logic signed [63:0] p_s12, sq_s12, y_s12;
	logic signed [31:0] temp_s12;
	// Post stage 3: product with p9.
	logic v_s13, dz_s13;
	logic signed [63:0] p_s13, x_s13, y_s13;
	logic signed [31:0] temp_s13;
	// Output register.
	logic [31:0] press_q, temp_q;
	logic dz_q;

	logic signed [63:0] pq_c;
	assign pq_c = dside[33] ? -$signed(dq) : $signed(dq);

	// Low 64 bits of the square from 32-bit halves: the high-by-high term
	// drops out and the two cross terms are equal.
	logic [31:0] psl_c, psh_c, sq_lh_c;
	logic [63:0] sq_ll_c;
	assign psl_c   = ps_s11[31:0];
	assign psh_c   = ps_s11[63:32];
	assign sq_ll_c = {32'd0, psl_c} * {32'd0, psl_c};
	assign sq_lh_c = psl_c * psh_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; out_v <= 1'b0;
		end else if (en) begin
			v_s11 <= dv_v; v_s12 <= v_s11; v_s13 <= v_s12; out_v <= v_s13;
		end
	end

	logic signed [63:0] pf_c;
	assign pf_c = ((p_s13 + x_s13 + y_s13) >>> 8) + (p7 <<< 4);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s11    <= pq_c;
			ps_s11   <= pq_c >>> 13;
			dz_s11   <= dside[32];
			temp_s11 <= dside[31:0];

			p_s12    <= p_s11;
			sq_s12   <= sq_ll_c + {sq_lh_c[30:0], 33'd0};
			y_s12    <= (p8 * p_s11) >>> 19;
			dz_s12   <= dz_s11;
			temp_s12 <= temp_s11;

			p_s13    <= p_s12;
			x_s13    <= (p9 * sq_s12) >>> 25;
			y_s13    <= y_s12;
			dz_s13   <= dz_s12;
			temp_s13 <= temp_s12;

			press_q <= dz_s13 ? 32'd0 : pf_c[31:0];
			dz_q    <= dz_s13;
			temp_q  <= temp_s13;
		end
	end

	assign out_ch.valid = out_v;
	assign out_ch.data  = {dz_q, press_q, temp_q};

`ifndef SYNTHESIS
	// A stalled result must hold its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && !out_ch.ready |=> out_v && $stable(out_ch.data))
		else $error("result changed under stall");
	// The input is refused exactly when the output is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_v || out_ch.ready))
		else $error("ready mismatch");
	// A zero-divisor result carries no pressure.
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && dz_q |-> press_q == 32'd0)
		else $error("pressure not cleared on zero divisor");
`endif
endmodule
